### design/http_request_parser_assert.svh
// assertion macros for the http request parser
// expects clk and rst in the scope of the including module
`ifndef HTTP_REQUEST_PARSER_ASSERT_SVH
`define HTTP_REQUEST_PARSER_ASSERT_SVH

// plain invariant checked at every edge out of reset
`define HRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// guarded property, the condition implies the property in the same cycle
`define HRP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// guarded property, the condition implies the property in the next cycle
`define HRP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### design/hrp_pkg.sv
// shared types and constants of the http request parser
// no dependencies
package hrp_pkg;

  localparam int OUT_LEN_BITS = 31;

  // result kinds
  localparam logic [2:0] KIND_METHOD   = 3'd0;
  localparam logic [2:0] KIND_URL      = 3'd1;
  localparam logic [2:0] KIND_VERSION  = 3'd2;
  localparam logic [2:0] KIND_HEADER   = 3'd3;
  localparam logic [2:0] KIND_LINE_END = 3'd4;
  localparam logic [2:0] KIND_BODY     = 3'd5;
  localparam logic [2:0] KIND_NONE     = 3'd6;

  // status codes
  localparam logic [1:0] STATUS_MORE  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // header line classes
  localparam logic [1:0] CLS_MATCH  = 2'd0;
  localparam logic [1:0] CLS_LENGTH = 2'd1;
  localparam logic [1:0] CLS_CONN   = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  // length value scan
  localparam logic [1:0] NUM_SKIP   = 2'd0;
  localparam logic [1:0] NUM_SIGN   = 2'd1;
  localparam logic [1:0] NUM_DIGITS = 2'd2;
  localparam logic [1:0] NUM_END    = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_K = 8'h6b;
  localparam logic [7:0] CH_LOW_L = 8'h6c;
  localparam logic [7:0] CH_LOW_N = 8'h6e;
  localparam logic [7:0] CH_LOW_T = 8'h74;

  localparam logic [3:0] LENGTH_PAT_LEN = 4'd15;
  localparam logic [3:0] CONN_PAT_LEN   = 4'd11;
  localparam logic [3:0] ALIVE_PAT_LEN  = 4'd10;
  localparam logic [3:0] CASE_POS       = 4'd8;
  localparam logic [3:0] CLASS_POS      = 4'd3;

  localparam logic [0:14][7:0] LENGTH_PAT = "Content-Length:";
  localparam logic [0:10][7:0] CONN_PAT   = "Connection:";
  localparam logic [0:9][7:0]  ALIVE_PAT  = "keep-alive";

  typedef struct packed {
    logic                    last;
    logic [OUT_LEN_BITS-1:0] body_length;
    logic                    alive;
    logic [1:0]              status;
    logic [7:0]              out_byte;
    logic [2:0]              kind;
  } result_t;

endpackage

### design/http_request_parser.sv
// http request parser, one request byte per beat, byte tagging and header decode
// depends on hrp_pkg and http_request_parser_assert.svh
//
// Takes one byte per cycle and gives zero, one or two result beats for it: a CR in the
// request line or header is held until the next byte, which releases it either as the
// line end (CR LF, one beat) or as an ordinary byte followed by the new one (two beats).
// The per-byte state update is a single pass of logic into the state registers, and the
// results go into a four-entry result queue, so input is taken every cycle while the
// queue holds at most two beats. Length values saturate at 2^LENGTH_BITS-1 and are
// shown clipped to 31 bits.
`include "http_request_parser_assert.svh"

module http_request_parser
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // action
  input  logic        s_tlast,   // chunk_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_byte, status, alive, body_length, zero fill
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  typedef enum logic [2:0] {PH_REQ, PH_HDR, PH_BODY, PH_DONE, PH_ERR} phase_t;

  typedef struct packed {
    logic [1:0]             space_count;
    logic                   line_start;
    logic [3:0]             prefix_pos;
    logic [1:0]             header_class;
    logic [1:0]             number_phase;
    logic                   negative_sign;
    logic [LENGTH_BITS-1:0] length_accum;
    logic [3:0]             keyword_pos;
  } line_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  function automatic line_t line_init();
    line_t r;
    r = '0;
    r.line_start = 1'b1;
    return r;
  endfunction

  function automatic line_t clear_line(input line_t s);
    line_t r;
    r = s;
    r.prefix_pos    = '0;
    r.header_class  = CLS_MATCH;
    r.number_phase  = NUM_SKIP;
    r.negative_sign = 1'b0;
    r.length_accum  = '0;
    r.keyword_pos   = '0;
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] add_digit(input logic [LENGTH_BITS-1:0] acc,
                                                        input logic [7:0] b);
    logic [LENGTH_BITS+3:0] prod;
    logic [LENGTH_BITS+3:0] wide;
    wide = {4'b0, acc};
    prod = (wide << 3) + (wide << 1) + (LENGTH_BITS+4)'(b - CH_ZERO);
    if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) return LEN_MAX;
    return prod[LENGTH_BITS-1:0];
  endfunction

  function automatic line_t number_byte(input line_t s, input logic [7:0] b);
    line_t r;
    logic  dig;
    logic  ws;
    r   = s;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    ws  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    case (s.number_phase)
      NUM_SKIP: begin
        if (!ws) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            r.negative_sign = (b == CH_MINUS);
            r.number_phase  = NUM_SIGN;
          end else if (dig) begin
            r.length_accum = add_digit(s.length_accum, b);
            r.number_phase = NUM_DIGITS;
          end else begin
            r.header_class = CLS_OTHER;
          end
        end
      end
      NUM_SIGN: begin
        if (dig) begin
          r.length_accum = add_digit(s.length_accum, b);
          r.number_phase = NUM_DIGITS;
        end else begin
          r.header_class = CLS_OTHER;
        end
      end
      NUM_DIGITS: begin
        if (dig) r.length_accum = add_digit(s.length_accum, b);
        else r.number_phase = NUM_END;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic line_t header_byte(input line_t s, input logic [7:0] b);
    line_t r;
    r = s;
    r.line_start = 1'b0;
    if (s.header_class == CLS_LENGTH && s.prefix_pos == LENGTH_PAT_LEN) begin
      r = number_byte(r, b);
    end else if (s.header_class == CLS_CONN && s.prefix_pos == CONN_PAT_LEN) begin
      if (s.keyword_pos < ALIVE_PAT_LEN) begin
        if (b == ALIVE_PAT[s.keyword_pos]) r.keyword_pos = s.keyword_pos + 4'd1;
        else r.keyword_pos = (b == CH_LOW_K) ? 4'd1 : 4'd0;
      end
    end else if (s.header_class == CLS_MATCH) begin
      if (s.prefix_pos < CLASS_POS && b == LENGTH_PAT[s.prefix_pos]) begin
        r.prefix_pos = s.prefix_pos + 4'd1;
      end else if (s.prefix_pos == CLASS_POS && b == CH_LOW_T) begin
        r.header_class = CLS_LENGTH;
        r.prefix_pos   = CLASS_POS + 4'd1;
      end else if (s.prefix_pos == CLASS_POS && b == CH_LOW_N) begin
        r.header_class = CLS_CONN;
        r.prefix_pos   = CLASS_POS + 4'd1;
      end else begin
        r.header_class = CLS_OTHER;
        r.prefix_pos   = '0;
      end
    end else if (s.header_class == CLS_LENGTH && s.prefix_pos < LENGTH_PAT_LEN) begin
      if (b == LENGTH_PAT[s.prefix_pos] || (s.prefix_pos == CASE_POS && b == CH_LOW_L)) begin
        r.prefix_pos = s.prefix_pos + 4'd1;
      end else begin
        r.header_class = CLS_OTHER;
        r.prefix_pos   = '0;
      end
    end else if (s.header_class == CLS_CONN && s.prefix_pos < CONN_PAT_LEN) begin
      if (b == CONN_PAT[s.prefix_pos]) begin
        r.prefix_pos = s.prefix_pos + 4'd1;
      end else begin
        r.header_class = CLS_OTHER;
        r.prefix_pos   = '0;
      end
    end
    return r;
  endfunction

  function automatic line_t line_byte(input line_t s, input logic in_req, input logic [7:0] b,
                                      output logic [2:0] kind);
    line_t r;
    r = s;
    if (in_req) begin
      if (b == CH_SPACE && s.space_count < 2'd2) begin
        r.space_count = s.space_count + 2'd1;
        kind = KIND_NONE;
      end else begin
        kind = {1'b0, s.space_count};
      end
    end else begin
      r = header_byte(s, b);
      kind = KIND_HEADER;
    end
    return r;
  endfunction

  // registers
  phase_t                 phase;
  line_t                  line;
  logic                   pending_cr;
  logic                   alive_flag;
  logic [LENGTH_BITS-1:0] length_target;
  logic [LENGTH_BITS-1:0] body_count;
  result_t                queue [4];
  logic [1:0]             head;
  logic [1:0]             tail;
  logic [2:0]             count;

  // next values
  phase_t                  phase_next;
  line_t                   line_next;
  logic                    pending_cr_next;
  logic                    alive_flag_next;
  logic [LENGTH_BITS-1:0]  length_target_next;
  logic [LENGTH_BITS-1:0]  body_count_next;
  logic [1:0]              n_res;
  logic [2:0]              kind0;
  logic [2:0]              kind1;
  logic [7:0]              byte0;
  logic [7:0]              byte1;
  logic [OUT_LEN_BITS-1:0] len_shown;
  logic [1:0]              status_next;
  result_t                 res0;
  result_t                 res1;
  logic                    in_fire;
  logic                    out_fire;
  logic [7:0]              b;
  logic                    in_req;

  assign b        = s_tdata;
  assign in_req   = (phase == PH_REQ);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);
  assign m_tvalid = (count != 3'd0);

  always_comb begin
    phase_next         = phase;
    line_next          = line;
    pending_cr_next    = pending_cr;
    alive_flag_next    = alive_flag;
    length_target_next = length_target;
    body_count_next    = body_count;
    n_res              = 2'd0;
    kind0              = KIND_NONE;
    byte0              = 8'd0;
    kind1              = KIND_NONE;
    byte1              = 8'd0;
    if (s_tuser) begin
      phase_next              = PH_REQ;
      line_next               = clear_line(line);
      line_next.space_count   = 2'd0;
      line_next.line_start    = 1'b1;
      pending_cr_next         = 1'b0;
      alive_flag_next         = 1'b0;
      length_target_next      = '0;
      body_count_next         = '0;
      n_res                   = 2'd1;
    end else if (phase == PH_ERR || phase == PH_DONE) begin
      n_res = 2'd1;
    end else if (phase == PH_BODY) begin
      body_count_next = body_count + 1'b1;
      if (body_count_next >= length_target) phase_next = PH_DONE;
      kind0 = KIND_BODY;
      byte0 = b;
      n_res = 2'd1;
    end else if (pending_cr) begin
      pending_cr_next = 1'b0;
      if (b == CH_LF) begin
        n_res = 2'd1;
        if (in_req) begin
          if (line.space_count < 2'd2) begin
            phase_next = PH_ERR;
          end else begin
            phase_next           = PH_HDR;
            line_next            = clear_line(line);
            line_next.line_start = 1'b1;
          end
        end else if (line.line_start) begin
          phase_next = (length_target != '0) ? PH_BODY : PH_DONE;
        end else if (line.prefix_pos == LENGTH_PAT_LEN && (line.header_class == CLS_OTHER ||
                     (line.header_class == CLS_LENGTH && line.number_phase < NUM_DIGITS))) begin
          phase_next = PH_ERR;
        end else begin
          if (line.header_class == CLS_LENGTH && line.prefix_pos == LENGTH_PAT_LEN)
            length_target_next = line.negative_sign ? '0 : line.length_accum;
          if (line.header_class == CLS_CONN && line.prefix_pos == CONN_PAT_LEN &&
              line.keyword_pos >= ALIVE_PAT_LEN)
            alive_flag_next = 1'b1;
          line_next            = clear_line(line);
          line_next.line_start = 1'b1;
          kind0                = KIND_LINE_END;
          byte0                = CH_LF;
        end
      end else begin
        line_next = line_byte(line, in_req, CH_CR, kind0);
        byte0     = (kind0 == KIND_NONE) ? 8'd0 : CH_CR;
        if (b == CH_CR) begin
          pending_cr_next = 1'b1;
          n_res           = 2'd1;
        end else begin
          line_next = line_byte(line_next, in_req, b, kind1);
          byte1     = (kind1 == KIND_NONE) ? 8'd0 : b;
          n_res     = 2'd2;
        end
      end
    end else if (b == CH_CR) begin
      pending_cr_next = 1'b1;
    end else begin
      line_next = line_byte(line, in_req, b, kind0);
      byte0     = (kind0 == KIND_NONE) ? 8'd0 : b;
      n_res     = 2'd1;
    end
  end

  generate
    if (LENGTH_BITS > OUT_LEN_BITS) begin : g_clip
      assign len_shown = (|length_target_next[LENGTH_BITS-1:OUT_LEN_BITS]) ?
                         {OUT_LEN_BITS{1'b1}} : length_target_next[OUT_LEN_BITS-1:0];
    end else begin : g_extend
      assign len_shown = OUT_LEN_BITS'(length_target_next);
    end
  endgenerate

  always_comb begin
    unique case (phase_next)
      PH_ERR:  status_next = STATUS_ERROR;
      PH_DONE: status_next = STATUS_DONE;
      default: status_next = STATUS_MORE;
    endcase
    res0.kind        = kind0;
    res0.out_byte    = byte0;
    res0.status      = status_next;
    res0.alive       = alive_flag_next;
    res0.body_length = len_shown;
    res0.last        = (n_res == 2'd1);
    res1.kind        = kind1;
    res1.out_byte    = byte1;
    res1.status      = status_next;
    res1.alive       = alive_flag_next;
    res1.body_length = len_shown;
    res1.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_REQ;
      line          <= line_init();
      pending_cr    <= 1'b0;
      alive_flag    <= 1'b0;
      length_target <= '0;
      body_count    <= '0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
    end else begin
      if (in_fire) begin
        phase         <= phase_next;
        line          <= line_next;
        pending_cr    <= pending_cr_next;
        alive_flag    <= alive_flag_next;
        length_target <= length_target_next;
        body_count    <= body_count_next;
        if (n_res != 2'd0) queue[tail] <= res0;
        if (n_res == 2'd2) queue[tail + 2'd1] <= res1;
        tail <= tail + n_res;
      end
      if (out_fire) head <= head + 2'd1;
      count <= count + (in_fire ? {1'b0, n_res} : 3'd0) - {2'b0, out_fire};
    end
  end

  assign m_tuser = queue[head].kind;
  assign m_tlast = queue[head].last;
  assign m_tdata = {6'd0, queue[head].body_length, queue[head].alive,
                    queue[head].status, queue[head].out_byte};

  `HRP_ASSERT(a_queue_bound, count <= 3'd4, "result queue overflow")
  `HRP_ASSERT_IMP(a_cr_held_in_text, pending_cr, phase == PH_REQ || phase == PH_HDR,
                  "cr held outside request line or header")
  `HRP_ASSERT_IMP(a_body_in_range, phase == PH_BODY, body_count < length_target,
                  "body count reached length without finishing")
  `HRP_ASSERT_NEXT(a_restart_beat, in_fire && s_tuser, count != 3'd0,
                   "restart gave no beat")

endmodule
